// ===== hdl/rc4_pkg.sv =====
package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = 8;
    localparam int KEY_DEPTH_DEF = 256;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_D_J   = 8'b0000_0010,
        ST_D_T   = 8'b0000_0100,
        ST_D_OUT = 8'b0000_1000,
        ST_K_N   = 8'b0001_0000,
        ST_K_J   = 8'b0010_0000,
        ST_K_W1  = 8'b0100_0000,
        ST_K_W2  = 8'b1000_0000
    } state_t;

endpackage

// ===== hdl/rc4_ram.sv =====
module rc4_ram #(
    parameter int WIDTH = rc4_pkg::BYTE_W,
    parameter int DEPTH = rc4_pkg::PERM_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and a write to the same entry return the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rc4_stream_cipher_core.sv =====
// RC4 cipher core. Key bytes (command 0) are buffered; the key byte marked last starts
// the key schedule, which holds in_stall high through a setup step and then 256 swap
// steps, each through ST_K_J, ST_K_W1 and ST_K_W2. Each data byte (command 1) passes
// through ST_D_J, ST_D_T and ST_D_OUT, waiting in ST_D_OUT on a stalled output. The
// permutation lives in one RAM with one read and one write port, and the read of S[i],
// the read of S[j] and the read of S[i]+S[j] depend on each other; the two swap writes
// overlap the last two reads. The result sits in an output register, so the next byte
// is taken while it waits. The permutation resets to identity through per-entry valid
// bits, and the key schedule restores identity the same way without a clearing pass.
module rc4_stream_cipher_core #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic [rc4_pkg::BYTE_W-1:0] value,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [rc4_pkg::BYTE_W-1:0] out_byte
);

    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CW  = $clog2(KEY_DEPTH + 1);
    localparam int BW  = rc4_pkg::BYTE_W;
    localparam int PAW = rc4_pkg::PERM_AW;
    localparam int PD  = rc4_pkg::PERM_DEPTH;

    rc4_pkg::state_t state_reg, state_next;

    logic [PAW-1:0] i_reg, i_next;
    logic [PAW-1:0] j_reg, j_next;
    logic [PAW-1:0] n_reg, n_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [BW-1:0]  a_reg, a_next;
    logic [BW-1:0]  data_reg, data_next;
    logic           out_valid_reg, out_valid_next;
    logic [BW-1:0]  out_byte_reg, out_byte_next;
    logic [PD-1:0]  valid_reg, valid_next;

    // read-side capture for forwarding and identity fill
    logic [PAW-1:0] rd_addr_reg;
    logic           rd_valid_reg;
    logic           hit_reg;
    logic [BW-1:0]  hit_data_reg;

    logic           perm_we, perm_re;
    logic [PAW-1:0] perm_waddr, perm_raddr;
    logic [BW-1:0]  perm_wdata, perm_rdata;
    logic           key_we, key_re;
    logic [KAW-1:0] key_waddr, key_raddr;
    logic [BW-1:0]  key_wdata, key_rdata;

    logic           accept_en;
    logic           clear;
    logic           out_free;
    logic [BW-1:0]  s_rd;
    logic [BW-1:0]  ks;
    logic [CW-1:0]  k_inc, len_eff, k_wrap;

    rc4_ram #(.WIDTH(BW), .DEPTH(PD)) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .re    (perm_re),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    rc4_ram #(.WIDTH(BW), .DEPTH(KEY_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // entry not yet written since identity fill reads as its own index
    assign s_rd = hit_reg ? hit_data_reg :
                  (rd_valid_reg ? perm_rdata : rd_addr_reg);
    // the S[j] write lands after the S[t] read, so it overrides
    assign ks       = (rd_addr_reg == j_reg) ? a_reg : s_rd;
    assign out_free = !out_valid_reg || !out_stall;

    assign k_inc   = CW'(k_reg + 1'b1);
    assign len_eff = (count_reg == '0) ? CW'(1) : count_reg;
    assign k_wrap  = (k_inc == len_eff) ? '0 : k_inc;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        a_next         = a_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        perm_we        = 1'b0;
        perm_waddr     = i_reg;
        perm_wdata     = s_rd;
        perm_re        = 1'b0;
        perm_raddr     = PAW'(i_reg + 1'b1);
        key_we         = 1'b0;
        key_waddr      = count_reg[KAW-1:0];
        key_wdata      = value;
        key_re         = 1'b0;
        key_raddr      = k_reg[KAW-1:0];
        clear          = 1'b0;
        accept_en      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                accept_en = 1'b1;
            end
            rc4_pkg::ST_D_J:
            begin
                a_next     = s_rd;
                j_next     = PAW'(j_reg + s_rd);
                perm_re    = 1'b1;
                perm_raddr = j_next;
                state_next = rc4_pkg::ST_D_T;
            end
            rc4_pkg::ST_D_T:
            begin
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = s_rd;
                perm_re    = 1'b1;
                perm_raddr = PAW'(a_reg + s_rd);
                state_next = rc4_pkg::ST_D_OUT;
            end
            rc4_pkg::ST_D_OUT:
            begin
                // write repeats harmlessly while the output is held
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = a_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks;
                    accept_en      = 1'b1;
                    state_next     = rc4_pkg::ST_IDLE;
                end
            end
            rc4_pkg::ST_K_N:
            begin
                perm_re    = 1'b1;
                perm_raddr = n_reg;
                key_re     = 1'b1;
                key_raddr  = k_reg[KAW-1:0];
                state_next = rc4_pkg::ST_K_J;
            end
            rc4_pkg::ST_K_J:
            begin
                a_next     = s_rd;
                j_next     = PAW'(j_reg + s_rd + key_rdata);
                perm_re    = 1'b1;
                perm_raddr = j_next;
                state_next = rc4_pkg::ST_K_W1;
            end
            rc4_pkg::ST_K_W1:
            begin
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = s_rd;
                state_next = rc4_pkg::ST_K_W2;
            end
            rc4_pkg::ST_K_W2:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = a_reg;
                if (n_reg == PAW'(PD - 1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    count_next = '0;
                    state_next = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    n_next     = PAW'(n_reg + 1'b1);
                    k_next     = k_wrap;
                    perm_re    = 1'b1;
                    perm_raddr = n_next;
                    key_re     = 1'b1;
                    key_raddr  = k_wrap[KAW-1:0];
                    state_next = rc4_pkg::ST_K_J;
                end
            end
            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase

        if (accept_en && in_valid)
        begin
            if (command)
            begin
                i_next     = PAW'(i_reg + 1'b1);
                data_next  = value;
                perm_re    = 1'b1;
                perm_raddr = i_next;
                state_next = rc4_pkg::ST_D_J;
            end
            else
            begin
                if (count_reg < CW'(KEY_DEPTH))
                begin
                    key_we     = 1'b1;
                    count_next = CW'(count_reg + 1'b1);
                end
                if (last)
                begin
                    clear      = 1'b1;
                    j_next     = '0;
                    n_next     = '0;
                    k_next     = '0;
                    state_next = rc4_pkg::ST_K_N;
                end
                else
                begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
        end

        valid_next = valid_reg;
        if (perm_we)
        begin
            valid_next[perm_waddr] = 1'b1;
        end
        if (clear)
        begin
            valid_next = '0;
        end
    end

    assign in_stall  = !accept_en;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
        if (perm_re)
        begin
            rd_addr_reg  <= perm_raddr;
            rd_valid_reg <= valid_reg[perm_raddr];
            hit_reg      <= perm_we && (perm_waddr == perm_raddr);
            hit_data_reg <= perm_wdata;
        end
    end

    a_out_from_dout: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rc4_pkg::ST_D_OUT))
        else $error("result appeared outside the output step");

    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_K_W2) && (n_reg == PAW'(PD - 1))
        |=> (count_reg == '0) && (i_reg == '0) && (j_reg == '0)
            && (state_reg == rc4_pkg::ST_IDLE))
        else $error("key schedule did not finish cleanly");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(KEY_DEPTH))
        else $error("key count beyond key buffer depth");

    a_data_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command |=> (state_reg == rc4_pkg::ST_D_J)
            && (i_reg == PAW'($past(i_reg) + 1'b1)))
        else $error("data beat did not start keystream step");

endmodule
